/* design/storage_io_load_and_speed_monitor_defines.svh */
// Assertion macros shared by the storage I/O monitor modules.
// Depends on nothing; included by files that carry assertions.
`ifndef STORAGE_IO_LOAD_AND_SPEED_MONITOR_DEFINES_SVH
`define STORAGE_IO_LOAD_AND_SPEED_MONITOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SIOM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication checked also during reset.
`define SIOM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* design/siom_pkg.sv */
// Package of the storage I/O monitor: widths, constants, shared structs.
// Depends on nothing.
`timescale 1ns / 1ps
package siom_pkg;
    localparam int BYTE_SUM_WIDTH = 32;
    localparam int BUSY_SUM_WIDTH = 64;
    localparam int DIV_W = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam logic [6:0] PCT_SCALE = 7'd100;
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    // Division by 100 is a shift by 2 and a division by 25; division by 10^6 is a
    // shift by 6 and a division by 15625. The odd parts use reciprocals scaled by 2^36.
    localparam logic [13:0] PCT_DIV_ODD = 14'd25;
    localparam logic [13:0] MS_DIV_ODD = 14'd15625;
    localparam logic [31:0] PCT_RECIP = 32'd2748779070;
    localparam logic [31:0] MS_RECIP = 32'd4398047;
    localparam int RECIP_SHIFT = 36;
    localparam logic [3:0] CDIV_DIGITS = 4'd8;

    localparam logic [1:0] CFG_WINDOW_NS = 2'd0;
    localparam logic [1:0] CFG_BUSY_PERCENT = 2'd1;
    localparam logic [1:0] CFG_LOW_SPEED_RATE = 2'd2;
    localparam logic [1:0] CFG_MAX_REPORTS = 2'd3;

    // Snapshot of the window sums handed from the front to the back part with each item.
    typedef struct packed {
        logic                      closed;
        logic [63:0]               elapsed;
        logic [BUSY_SUM_WIDTH-1:0] wr_busy;
        logic [BUSY_SUM_WIDTH-1:0] rd_busy;
        logic [BYTE_SUM_WIDTH-1:0] wr_bytes;
        logic [BYTE_SUM_WIDTH-1:0] rd_bytes;
        logic [15:0]               tally;
        logic                      clear_rep;
    } win_job_t;

    typedef struct packed {
        logic        window_closed;
        logic        low_load;
        logic [6:0]  total_load_pct;
        logic [6:0]  write_load_pct;
        logic [31:0] write_rate;
        logic        write_rate_valid;
        logic [31:0] read_rate;
        logic        read_rate_valid;
        logic [15:0] request_total;
        logic        slow_write_report;
    } result_t;
endpackage

/* design/storage_io_load_and_speed_monitor.sv */
// Top level of the storage I/O load and speed monitor.
// Depends on siom_pkg, siom_front, siom_queue and siom_back.
//
//  channel | direction | handshake             | payload
//  s_axis  | in        | s_tvalid / s_tready   | s_tdata: request fields
//  m_axis  | out       | m_tvalid / m_tready   | m_tdata: window report
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item that closes no window runs no division in the back part.
// A closing item runs up to four divisions by a variable on the restoring
// divider and three divisions by 100 or 10^6 on the constant divider.
// Reset is synchronous on aresetn and clears all sums and counters.
// The two-entry queue lets the front accept items while the back stalls.
`timescale 1ns / 1ps
module storage_io_load_and_speed_monitor import siom_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_time[63:0], busy_ns[95:64], has_request[96], is_write[97],
    // byte_count[121:98], clear_reports[122], zeros[127:123]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // window_closed[0], low_load[1], total_load_pct[8:2], write_load_pct[15:9],
    // write_rate[47:16], write_rate_valid[48], read_rate[80:49],
    // read_rate_valid[81], request_total[97:82], slow_write_report[98], zeros[103:99]
    output logic [103:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [39:0]  cfg_data
);
    logic [39:0] window_ns_reg;
    logic [6:0]  busy_percent_reg;
    logic [19:0] low_speed_rate_reg;
    logic [7:0]  max_reports_reg;

    logic f_valid, f_ready, q_valid, q_ready;
    win_job_t f_job, q_job;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ns_reg <= 40'd10000000000;
            busy_percent_reg <= 7'd90;
            low_speed_rate_reg <= 20'd2048;
            max_reports_reg <= 8'd10;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_NS:      window_ns_reg <= cfg_data;
                CFG_BUSY_PERCENT:   busy_percent_reg <= cfg_data[6:0];
                CFG_LOW_SPEED_RATE: low_speed_rate_reg <= cfg_data[19:0];
                CFG_MAX_REPORTS:    max_reports_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    siom_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .start_time(s_tdata[63:0]), .busy_ns(s_tdata[95:64]),
        .has_request(s_tdata[96]), .is_write(s_tdata[97]),
        .byte_count(s_tdata[121:98]), .clear_reports(s_tdata[122]),
        .window_ns(window_ns_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    siom_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    siom_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .busy_percent(busy_percent_reg), .low_speed_rate(low_speed_rate_reg),
        .max_reports(max_reports_reg),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {5'd0, res.slow_write_report, res.request_total,
                      res.read_rate_valid, res.read_rate,
                      res.write_rate_valid, res.write_rate,
                      res.write_load_pct, res.total_load_pct,
                      res.low_load, res.window_closed};
endmodule

/* design/siom_front.sv */
// Front part: keeps the window sums and decides per item whether a window closes.
// Depends on siom_pkg.
`timescale 1ns / 1ps
module siom_front import siom_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] start_time,
    input  logic [31:0] busy_ns,
    input  logic        has_request,
    input  logic        is_write,
    input  logic [23:0] byte_count,
    input  logic        clear_reports,
    input  logic [39:0] window_ns,
    output logic        job_valid,
    input  logic        job_ready,
    output win_job_t    job
);
    logic [63:0] win_start_reg;
    logic [BUSY_SUM_WIDTH-1:0] wr_busy_reg, rd_busy_reg;
    logic [BYTE_SUM_WIDTH-1:0] wr_bytes_reg, rd_bytes_reg;
    logic [15:0] tally_reg;

    logic [63:0] start_eff, elapsed;
    logic closing, take;
    logic [BUSY_SUM_WIDTH-1:0] wb_base, rb_base;
    logic [BYTE_SUM_WIDTH-1:0] wy_base, ry_base;
    logic [15:0] t_base;
    logic [BUSY_SUM_WIDTH:0] busy_sum;
    logic [BYTE_SUM_WIDTH:0] byte_sum;
    logic [BUSY_SUM_WIDTH-1:0] add_busy_base;
    logic [BYTE_SUM_WIDTH-1:0] add_byte_base;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign take      = in_valid && job_ready;

    always_comb begin
        start_eff = (win_start_reg == 64'd0) ? start_time : win_start_reg;
        elapsed   = start_time - start_eff;
        closing   = (elapsed >= {24'd0, window_ns});
        job.closed    = closing;
        job.elapsed   = elapsed;
        job.wr_busy   = wr_busy_reg;
        job.rd_busy   = rd_busy_reg;
        job.wr_bytes  = wr_bytes_reg;
        job.rd_bytes  = rd_bytes_reg;
        job.tally     = tally_reg;
        job.clear_rep = clear_reports;
        wb_base = closing ? '0 : wr_busy_reg;
        rb_base = closing ? '0 : rd_busy_reg;
        wy_base = closing ? '0 : wr_bytes_reg;
        ry_base = closing ? '0 : rd_bytes_reg;
        t_base  = closing ? '0 : tally_reg;
        add_busy_base = is_write ? wb_base : rb_base;
        add_byte_base = is_write ? wy_base : ry_base;
        busy_sum = {1'b0, add_busy_base} + {{(BUSY_SUM_WIDTH-31){1'b0}}, busy_ns};
        byte_sum = {1'b0, add_byte_base} + {{(BYTE_SUM_WIDTH-23){1'b0}}, byte_count};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg <= '0;
            wr_busy_reg <= '0;
            rd_busy_reg <= '0;
            wr_bytes_reg <= '0;
            rd_bytes_reg <= '0;
            tally_reg <= '0;
        end else if (take) begin
            win_start_reg <= closing ? start_time : start_eff;
            wr_busy_reg  <= wb_base;
            rd_busy_reg  <= rb_base;
            wr_bytes_reg <= wy_base;
            rd_bytes_reg <= ry_base;
            tally_reg    <= t_base;
            if (has_request) begin
                // Sums saturate at their full width.
                if (is_write) begin
                    wr_busy_reg  <= busy_sum[BUSY_SUM_WIDTH] ? '1 :
                                    busy_sum[BUSY_SUM_WIDTH-1:0];
                    wr_bytes_reg <= byte_sum[BYTE_SUM_WIDTH] ? '1 :
                                    byte_sum[BYTE_SUM_WIDTH-1:0];
                end else begin
                    rd_busy_reg  <= busy_sum[BUSY_SUM_WIDTH] ? '1 :
                                    busy_sum[BUSY_SUM_WIDTH-1:0];
                    rd_bytes_reg <= byte_sum[BYTE_SUM_WIDTH] ? '1 :
                                    byte_sum[BYTE_SUM_WIDTH-1:0];
                end
                tally_reg <= (t_base == 16'hFFFF) ? t_base : t_base + 16'd1;
            end
        end
    end
endmodule

/* design/siom_queue.sv */
// Two-entry queue carrying window jobs from the front to the back part.
// Depends on siom_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "storage_io_load_and_speed_monitor_defines.svh"
module siom_queue import siom_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  win_job_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output win_job_t rd_data
);
    win_job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `SIOM_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3, "queue count out of range")
    `SIOM_ASSERT(a_full_ptrs, aclk, aresetn, (cnt_reg == 2'd2) |-> (wp_reg == rp_reg),
        "full queue pointers differ")
    `SIOM_ASSERT(a_empty_ptrs, aclk, aresetn, (cnt_reg == 2'd0) |-> (wp_reg == rp_reg),
        "empty queue pointers differ")
endmodule

/* design/siom_divider.sv */
// Shared restoring divider, one quotient bit per cycle over 64 bits, and a
// constant divider by 100 or 10^6 that works one byte at a time.
// Depends on siom_pkg.
`timescale 1ns / 1ps
module siom_divider import siom_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);
    logic [DIV_W-1:0] q_reg, r_reg, d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic [DIV_W:0] trial;

    assign trial = {r_reg, q_reg[DIV_W-1]} - {1'b0, d_reg};
    assign quotient = q_reg;
    assign done = busy_reg && (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= DIV_CNT_W'(DIV_W);
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
                if (!trial[DIV_W]) begin
                    r_reg <= trial[DIV_W-1:0];
                    q_reg <= {q_reg[DIV_W-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[DIV_W-2:0], q_reg[DIV_W-1]};
                    q_reg <= {q_reg[DIV_W-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// The dividend is shifted right by 2 or 6 and then divided by 25 or 15625, one
// byte at a time from the top: a reciprocal multiply gives the quotient byte,
// and the next cycle takes the new remainder.
module siom_cdiv import siom_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             by_ms,
    input  logic [DIV_W-1:0] dividend,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);
    logic [63:0] n_reg, q_reg;
    logic [13:0] r_reg, d_reg;
    logic [31:0] m_reg;
    logic [7:0]  qd_reg;
    logic [3:0]  cnt_reg;
    logic        phase_reg, busy_reg;
    logic [21:0] x;
    logic [53:0] prod;
    logic [21:0] back_prod;

    assign x = {r_reg, n_reg[63:56]};
    assign prod = {32'd0, x} * {22'd0, m_reg};
    assign back_prod = {14'd0, qd_reg} * {8'd0, d_reg};
    assign done = busy_reg && (cnt_reg == 4'd0);
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 4'd0;
            phase_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= CDIV_DIGITS;
            phase_reg <= 1'b0;
            n_reg <= by_ms ? {6'd0, dividend[63:6]} : {2'd0, dividend[63:2]};
            d_reg <= by_ms ? MS_DIV_ODD : PCT_DIV_ODD;
            m_reg <= by_ms ? MS_RECIP : PCT_RECIP;
            r_reg <= '0;
            q_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == 4'd0) begin
                busy_reg <= 1'b0;
            end else if (!phase_reg) begin
                // The remainder stays below the divisor, so the byte quotient fits 8 bits.
                qd_reg <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
                phase_reg <= 1'b1;
            end else begin
                r_reg <= x[13:0] - back_prod[13:0];
                q_reg <= {q_reg[55:0], qd_reg};
                n_reg <= {n_reg[55:0], 8'd0};
                cnt_reg <= cnt_reg - 4'd1;
                phase_reg <= 1'b0;
            end
        end
    end
endmodule

/* design/siom_back.sv */
// Back part: turns a closed window into percentages, rates and the slow report.
// Depends on siom_pkg, siom_divider and the assertion macro header.
`timescale 1ns / 1ps
`include "storage_io_load_and_speed_monitor_defines.svh"
module siom_back import siom_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    output logic        job_ready,
    input  win_job_t    job,
    input  logic [6:0]  busy_percent,
    input  logic [19:0] low_speed_rate,
    input  logic [7:0]  max_reports,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PDIV  = 4'd1;
    localparam logic [3:0] ST_TPCT  = 4'd2;
    localparam logic [3:0] ST_WPCT  = 4'd3;
    localparam logic [3:0] ST_WMS   = 4'd4;
    localparam logic [3:0] ST_WRATE = 4'd5;
    localparam logic [3:0] ST_RMS   = 4'd6;
    localparam logic [3:0] ST_RRATE = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_WAIT  = 4'd9;

    logic [3:0] state_reg;
    win_job_t job_reg;
    result_t res_reg;
    logic [63:0] usage_reg, pdiv_reg, wms_reg, rms_reg;
    logic low_reg, slow_streak_reg, out_valid_reg;
    logic [7:0] reports_reg;
    logic launched_reg;

    logic div_start, div_done;
    logic [63:0] div_a, div_b, div_q;
    logic cdiv_state, by_ms, gdiv_start, cdiv_start, gdiv_done, cdiv_done;
    logic [63:0] gdiv_q, cdiv_q;
    logic [64:0] usage_full;
    logic [70:0] usage_x100;
    logic [6:0] q_cap;
    logic [31:0] r_cap;
    logic [7:0] reports_eff;

    siom_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(gdiv_start),
        .dividend(div_a), .divisor(div_b), .done(gdiv_done), .quotient(gdiv_q)
    );

    siom_cdiv u_cdiv (
        .aclk(aclk), .aresetn(aresetn), .start(cdiv_start), .by_ms(by_ms),
        .dividend(div_a), .done(cdiv_done), .quotient(cdiv_q)
    );

    // Divisions by 100 and by 10^6 go to the constant divider.
    assign cdiv_state = (state_reg == ST_PDIV) || (state_reg == ST_WMS) ||
                        (state_reg == ST_RMS);
    assign by_ms = (state_reg != ST_PDIV);
    assign gdiv_start = div_start && !cdiv_state;
    assign cdiv_start = div_start && cdiv_state;
    assign div_done = cdiv_state ? cdiv_done : gdiv_done;
    assign div_q = cdiv_state ? cdiv_q : gdiv_q;

    assign job_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res = res_reg;

    always_comb begin
        usage_full = {1'b0, job.wr_busy} + {1'b0, job.rd_busy};
        usage_x100 = {7'd0, usage_reg} * {64'd0, PCT_SCALE};
        q_cap = (div_q > 64'd100) ? 7'd100 : div_q[6:0];
        r_cap = (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
        reports_eff = job_reg.clear_rep ? 8'd0 : reports_reg;
        div_a = 64'd0;
        div_b = 64'd1;
        case (state_reg)
            ST_PDIV:  begin div_a = job_reg.elapsed; div_b = 64'd1; end
            ST_TPCT:  begin div_a = usage_reg; div_b = pdiv_reg; end
            ST_WPCT:  begin div_a = job_reg.wr_busy; div_b = pdiv_reg; end
            ST_WMS:   begin div_a = job_reg.wr_busy; div_b = 64'd1; end
            ST_WRATE: begin div_a = {32'd0, job_reg.wr_bytes}; div_b = wms_reg; end
            ST_RMS:   begin div_a = job_reg.rd_busy; div_b = 64'd1; end
            ST_RRATE: begin div_a = {32'd0, job_reg.rd_bytes}; div_b = rms_reg; end
            default:  begin div_a = 64'd0; div_b = 64'd1; end
        endcase
        div_start = !launched_reg && (state_reg != ST_IDLE) && (state_reg != ST_OUT)
                    && (state_reg != ST_WAIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            slow_streak_reg <= 1'b0;
            reports_reg <= 8'd0;
            launched_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) out_valid_reg <= 1'b0;
            launched_reg <= div_start ? 1'b1 : (div_done ? 1'b0 : launched_reg);
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid && job_ready) begin
                        job_reg <= job;
                        res_reg <= '0;
                        usage_reg <= usage_full[64] ? '1 : usage_full[63:0];
                        state_reg <= job.closed ? ST_WAIT : ST_OUT;
                    end
                end
                ST_WAIT: begin
                    // Low-load test needs usage*100 against elapsed; wide product registered.
                    low_reg <= (usage_x100[70:64] == 7'd0) &&
                               (job_reg.elapsed > usage_x100[63:0]);
                    res_reg.window_closed <= 1'b1;
                    res_reg.request_total <= job_reg.tally;
                    state_reg <= ST_PDIV;
                end
                ST_PDIV: if (div_done) begin
                    pdiv_reg <= (div_q == 64'd0) ? 64'd1 : div_q;
                    if (low_reg) begin
                        res_reg.low_load <= 1'b1;
                        state_reg <= ST_WMS;
                    end else begin
                        state_reg <= ST_TPCT;
                    end
                end
                ST_TPCT: if (div_done) begin
                    res_reg.total_load_pct <= q_cap;
                    state_reg <= ST_WPCT;
                end
                ST_WPCT: if (div_done) begin
                    res_reg.write_load_pct <= q_cap;
                    state_reg <= ST_WMS;
                end
                ST_WMS: if (div_done) begin
                    wms_reg <= div_q;
                    state_reg <= (div_q == 64'd0) ? ST_RMS : ST_WRATE;
                end
                ST_WRATE: if (div_done) begin
                    res_reg.write_rate <= r_cap;
                    res_reg.write_rate_valid <= 1'b1;
                    if ((res_reg.write_load_pct >= busy_percent) &&
                        (div_q < {44'd0, low_speed_rate})) begin
                        if (slow_streak_reg) begin
                            slow_streak_reg <= 1'b0;
                            if (reports_eff < max_reports) begin
                                reports_reg <= reports_eff + 8'd1;
                                res_reg.slow_write_report <= 1'b1;
                            end
                        end else begin
                            slow_streak_reg <= 1'b1;
                        end
                    end else begin
                        slow_streak_reg <= 1'b0;
                    end
                    state_reg <= ST_RMS;
                end
                ST_RMS: if (div_done) begin
                    rms_reg <= div_q;
                    state_reg <= (div_q == 64'd0) ? ST_OUT : ST_RRATE;
                end
                ST_RRATE: if (div_done) begin
                    res_reg.read_rate <= r_cap;
                    res_reg.read_rate_valid <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // The clear flag acts even when no window closes.
                    if (job_reg.clear_rep && !res_reg.slow_write_report) reports_reg <= 8'd0;
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SIOM_ASSERT(a_no_overrun, aclk, aresetn,
        (state_reg == ST_OUT) |-> !out_valid_reg, "result overwritten before taken")
    `SIOM_ASSERT(a_rep_limit, aclk, aresetn,
        $rose(res_reg.slow_write_report) |-> (reports_reg <= max_reports),
        "report count above limit")
    `SIOM_ASSERT(a_pct_range, aclk, aresetn,
        res_valid |-> (res.total_load_pct <= 7'd100 && res.write_load_pct <= 7'd100),
        "percentage above 100")
endmodule

/* test/tb_top.sv */
// Self-checking bench for the storage I/O load and speed monitor.
// Depends on siom_pkg and the storage_io_load_and_speed_monitor RTL.
`timescale 1ns / 1ps
module tb_top;
    import siom_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_WINDOW_NS;
    logic [39:0]  cfg_data = '0;

    typedef struct packed {
        logic        clear_reports;
        logic [23:0] byte_count;
        logic        is_write;
        logic        has_request;
        logic [31:0] busy_ns;
        logic [63:0] start_time;
    } request_t;

    // Directed row: the request plus an optional typed-in expected report.
    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } row_t;

    storage_io_load_and_speed_monitor DUT (.*);

    always #10 aclk = ~aclk;

    // Monitor copy of the configuration and window state.
    logic [39:0] win_len;
    logic [6:0]  busy_limit;
    logic [19:0] slow_rate;
    logic [7:0]  report_cap;
    logic [63:0] win_open;
    logic [63:0] wr_busy, rd_busy;
    logic [31:0] wr_bytes, rd_bytes;
    logic [15:0] req_count;
    logic        slow_pending;
    logic [7:0]  reports_done;

    result_t report_q[$];
    int      errors = 0;
    int      closes = 0;
    int      slow_reports = 0;
    longint  cycles = 0;
    bit      in_work = 1'b0;

    function automatic result_t expect_none();
        result_t r;
        r = '0;
        return r;
    endfunction

    // Splits the report bus into its fields, window_closed in the lowest bit.
    function automatic result_t unpack_report(logic [103:0] d);
        result_t r;
        r.window_closed = d[0];
        r.low_load = d[1];
        r.total_load_pct = d[8:2];
        r.write_load_pct = d[15:9];
        r.write_rate = d[47:16];
        r.write_rate_valid = d[48];
        r.read_rate = d[80:49];
        r.read_rate_valid = d[81];
        r.request_total = d[97:82];
        r.slow_write_report = d[98];
        return r;
    endfunction

    task automatic monitor_reset();
        win_len = 40'd10000000000; busy_limit = 7'd90;
        slow_rate = 20'd2048; report_cap = 8'd10;
        win_open = '0; wr_busy = '0; rd_busy = '0; wr_bytes = '0; rd_bytes = '0;
        req_count = '0; slow_pending = 1'b0; reports_done = '0;
    endtask

    function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] rate_of(logic [63:0] bytes, logic [63:0] busy);
        logic [63:0] q;
        q = bytes / (busy / 64'd1000000);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Works out the report for one request and advances the window state.
    function automatic result_t window_report(request_t rq);
        result_t     r;
        logic [63:0] elapsed, usage, div, w;
        logic [31:0] rate;
        r = '0;
        if (rq.clear_reports) reports_done = '0;
        if (win_open == 0) win_open = rq.start_time;
        elapsed = rq.start_time - win_open;
        if (elapsed >= {24'd0, win_len}) begin
            r.window_closed = 1'b1;
            usage = add_sat64(wr_busy, rd_busy);
            r.low_load = (usage > 64'hFFFF_FFFF_FFFF_FFFF / 100) ? 1'b0
                                                                : (elapsed > usage * 100);
            if (!r.low_load) begin
                div = elapsed / 100;
                if (div == 0) div = 1;
                w = usage / div;
                r.total_load_pct = (w > 100) ? 7'd100 : w[6:0];
                w = wr_busy / div;
                r.write_load_pct = (w > 100) ? 7'd100 : w[6:0];
            end
            if (wr_busy >= 64'd1000000) begin
                rate = rate_of({32'd0, wr_bytes}, wr_busy);
                r.write_rate = rate;
                r.write_rate_valid = 1'b1;
                // The rate compare uses the capped rate; bytes fit 32 bits, so the cap never acts and it is exact.
                if (r.write_load_pct >= busy_limit && rate < {12'd0, slow_rate}) begin
                    if (slow_pending) begin
                        slow_pending = 1'b0;
                        if (reports_done < report_cap) begin
                            reports_done++;
                            r.slow_write_report = 1'b1;
                        end
                    end else begin
                        slow_pending = 1'b1;
                    end
                end else begin
                    slow_pending = 1'b0;
                end
            end
            if (rd_busy >= 64'd1000000) begin
                r.read_rate = rate_of({32'd0, rd_bytes}, rd_busy);
                r.read_rate_valid = 1'b1;
            end
            r.request_total = req_count;
            win_open = rq.start_time;
            wr_busy = '0; rd_busy = '0; wr_bytes = '0; rd_bytes = '0; req_count = '0;
        end
        if (rq.has_request) begin
            if (rq.is_write) begin
                wr_busy = add_sat64(wr_busy, {32'd0, rq.busy_ns});
                wr_bytes = (wr_bytes > 32'hFFFF_FFFF - rq.byte_count) ? '1
                                                                    : wr_bytes + rq.byte_count;
            end else begin
                rd_busy = add_sat64(rd_busy, {32'd0, rq.busy_ns});
                rd_bytes = (rd_bytes > 32'hFFFF_FFFF - rq.byte_count) ? '1
                                                                    : rd_bytes + rq.byte_count;
            end
            if (req_count != 16'hFFFF) req_count++;
        end
        return r;
    endfunction

    // Result checking at the rising edge.
    always @(posedge aclk) begin
        result_t got, exp_r;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_report(m_tdata);
            if (report_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected report %h", got);
            end else begin
                exp_r = report_q.pop_front();
                if (got.window_closed) closes++;
                if (got.slow_write_report) slow_reports++;
                if (got !== exp_r || m_tdata[103:99] !== 5'd0) begin
                    errors++;
                    if (errors <= 10)
                        $display("report mismatch: expected %h got %h", exp_r, got);
                end
            end
        end
    end

    // Receiver stall pattern: quiet stretches alternate with random stalls.
    always @(negedge aclk) begin
        int phase;
        phase = int'((cycles / 500) % 3);
        m_tready <= (phase == 0) ? 1'b1 : (($urandom_range(0, 3) != 0) || phase == 2 && cycles[0]);
    end

    task automatic write_reg(logic [1:0] idx, logic [39:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WINDOW_NS:      win_len = val;
            CFG_BUSY_PERCENT:   busy_limit = val[6:0];
            CFG_LOW_SPEED_RATE: slow_rate = val[19:0];
            default:            report_cap = val[7:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drains all outstanding reports, then lets the back part settle.
    task automatic drain();
        while (report_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    // Sends one request; if typed, the queued expectation is the given one.
    task automatic send(request_t rq, bit typed, result_t want);
        result_t p;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, rq};
        do @(posedge aclk); while (!s_tready);
        p = window_report(rq);
        report_q.push_back(typed ? want : p);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Back-to-back variant for bursts: valid stays high across items.
    task automatic burst(request_t reqs[$]);
        result_t p;
        foreach (reqs[i]) begin
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata <= {5'd0, reqs[i]};
            do @(posedge aclk); while (!s_tready);
            p = window_report(reqs[i]);
            report_q.push_back(p);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic request_t mk(logic [63:0] t, logic [31:0] b, bit h, bit w,
                                    logic [23:0] n, bit c);
        request_t r;
        r.start_time = t; r.busy_ns = b; r.has_request = h; r.is_write = w;
        r.byte_count = n; r.clear_reports = c;
        return r;
    endfunction

    function automatic request_t rand_req(logic [63:0] t, int span);
        request_t r;
        r.start_time = t;
        r.busy_ns = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, span));
        r.has_request = ($urandom_range(0, 7) != 0);
        r.is_write = 1'($urandom_range(0, 1));
        r.byte_count = ($urandom_range(0, 5) == 0) ? 24'($urandom)
                                                   : 24'($urandom_range(0, 4096));
        r.clear_reports = ($urandom_range(0, 19) == 0);
        return r;
    endfunction

    initial begin
        row_t        rows[$];
        row_t        rw;
        request_t    reqs[$];
        result_t     none, w;
        logic [63:0] now;
        int          n, len;
        monitor_reset();
        none = expect_none();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset configuration.
        rw.typed = 1'b1; rw.want = none;
        rw.req = mk(64'd0, 32'd500, 1'b1, 1'b1, 24'd100, 1'b0); rows.push_back(rw);   // zero start: window unset
        rw.req = mk(64'd1000, '1, 1'b1, 1'b1, '1, 1'b0); rows.push_back(rw);
        rw.req = mk(64'd2000, '1, 1'b1, 1'b0, '1, 1'b1); rows.push_back(rw);
        rw.req = mk(64'd3000, 32'd0, 1'b0, 1'b0, 24'd0, 1'b0); rows.push_back(rw);
        rw.typed = 1'b0;
        rw.req = mk(64'd10000001000, 32'd5, 1'b1, 1'b0, 24'd7, 1'b0); rows.push_back(rw);
        // Time going backwards wraps elapsed and closes the window.
        rw.req = mk(64'd5, 32'd1, 1'b1, 1'b1, 24'd1, 1'b0); rows.push_back(rw);
        rw.req = mk('1, '1, 1'b1, 1'b1, '1, 1'b1); rows.push_back(rw);
        rw.req = mk(64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, 1'b0, 24'h80_0000, 1'b0);
        rows.push_back(rw);
        foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].want);
        drain();

        // Zero window length: every item closes; short elapsed checks the divisor floor.
        write_reg(CFG_WINDOW_NS, 40'd0);
        write_reg(CFG_BUSY_PERCENT, 40'd0);
        write_reg(CFG_LOW_SPEED_RATE, 40'hFFFFF);
        write_reg(CFG_MAX_REPORTS, 40'd0);
        now = 64'd100;
        for (int i = 0; i < 8; i++) begin
            now += 64'($urandom_range(0, 150));
            send(mk(now, 32'd3000000, 1'b1, i % 3 != 0, 24'd1000, 1'b0), 1'b0, none);
        end
        // A bare check empties the window, so the next one closes an empty window.
        send(mk(now, 32'd0, 1'b0, 1'b0, 24'd0, 1'b0), 1'b0, none);
        w = none; w.window_closed = 1'b1;
        send(mk(now, 32'd0, 1'b0, 1'b0, 24'd0, 1'b0), 1'b1, w);   // empty window, zero elapsed
        drain();
        write_reg(CFG_MAX_REPORTS, 40'd255);
        for (int i = 0; i < 6; i++) begin
            now += 64'd1000;
            send(mk(now, 32'd2000000, 1'b1, 1'b1, 24'd10, i == 3), 1'b0, none);
        end
        drain();

        // Random part: phases with different window lengths and thresholds.
        n = 0;
        while (n < 1250) begin
            case ($urandom_range(0, 4))
                0: write_reg(CFG_WINDOW_NS, 40'hFF_FFFF_FFFF);
                1: write_reg(CFG_WINDOW_NS, 40'd1);
                default: write_reg(CFG_WINDOW_NS, 40'($urandom_range(2000000, 40000000)));
            endcase
            write_reg(CFG_BUSY_PERCENT, ($urandom_range(0, 3) == 0) ? 40'd100
                                        : 40'($urandom_range(0, 100)));
            write_reg(CFG_LOW_SPEED_RATE, ($urandom_range(0, 3) == 0) ? 40'hFFFFF
                                          : 40'($urandom_range(0, 8192)));
            write_reg(CFG_MAX_REPORTS, ($urandom_range(0, 3) == 0) ? 40'd255
                                       : 40'($urandom_range(0, 4)));
            now = {$urandom, $urandom} >> $urandom_range(1, 40);
            for (int p = 0; p < 60 && n < 1250; p += len) begin
                len = $urandom_range(1, 8);
                reqs.delete();
                for (int k = 0; k < len; k++) begin
                    // Mostly forward time; now and then a jump back or to zero.
                    case ($urandom_range(0, 29))
                        0: now = 64'd0;
                        1: now = now - 64'($urandom_range(0, 100000));
                        2: now = {$urandom, $urandom};
                        default: now += 64'($urandom_range(0, 3000000));
                    endcase
                    reqs.push_back(rand_req(now, 3000000));
                end
                burst(reqs);
                n += len;
                repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(posedge aclk);
            end
            drain();
        end
        $display("Covered %0d requests, %0d closed windows, %0d slow-write reports.",
                 n, closes, slow_reports);
        if (errors == 0) begin
            $display("[storage_io_load_and_speed_monitor] OK");
        end else begin
            $display("%0d mismatches in total.", errors);
            $display("[storage_io_load_and_speed_monitor] ERROR");
        end
        $finish;
    end

    // Watchdog: generous against 1300 items plus stalls.
    always @(posedge aclk) begin
        if (cycles > 4000000) begin
            $display("[storage_io_load_and_speed_monitor] ERROR");
            $finish;
        end
    end
endmodule
